>>> rtl/tmps_pkg.sv
// ----------------------------------------------------------------------------
// tmps_pkg: shared types and constants for the triangle path-sum block
// widths, row-store depth and the structs passed between issue and update
// ----------------------------------------------------------------------------
package tmps_pkg;

  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned ROW_W    = $clog2(MAX_ROWS);
  localparam int unsigned VAL_W    = 8;
  localparam int unsigned SUM_W    = 14;
  localparam int unsigned CNT_W    = 7;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // item in flight between the read issue and the update stage
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    logic [ROW_W-1:0] addr;
    logic             first_col;
    logic             diag;
    logic             top_row;
    logic             rd_en;
    logic             last;
    logic             fwd;
    logic [SUM_W-1:0] fwd_data;
  } issue_t;

  // row-store write from the update stage
  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] addr;
    logic [SUM_W-1:0] data;
  } wr_t;

  // index of the last row for a given row count, with range clamping
  function automatic logic [ROW_W-1:0] last_row(input logic [CNT_W-1:0] cnt);
    int unsigned rc;
    rc = int'(cnt);
    if (rc == 0) rc = 1;
    if (rc > MAX_ROWS) rc = MAX_ROWS;
    return ROW_W'(rc - 1);
  endfunction

endpackage

>>> rtl/triangle_max_path_sum_top.sv
// ----------------------------------------------------------------------------
// triangle_max_path_sum_top: streaming maximum path sum of a number triangle
//
//   channel   dir   handshake              payload
//   in        in    in_valid_i/in_stall_o  entry_value_i (8b, row-major)
//   out       out   out_valid_o/out_stall_i max_sum_o (14b, one per triangle)
//   cfg       in    cfg_valid_i/cfg_ready_o row_count_i (7b)
//
// one item per cycle unless stalled; results pass issue and result registers
// two stages: row-store read issue, then add/compare and write back
// reset clears positions and carries; the row store is not cleared
// input stalls only while a finishing item waits on a full result register
// ----------------------------------------------------------------------------
module triangle_max_path_sum_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [tmps_pkg::VAL_W-1:0] entry_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tmps_pkg::SUM_W-1:0] max_sum_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tmps_pkg::CNT_W-1:0] row_count_i
);
  import tmps_pkg::*;

  issue_t           s1;
  wr_t              wr;
  logic             hold;
  logic             re;
  logic [ROW_W-1:0] raddr;
  logic [SUM_W-1:0] rdata;

  tmps_issue u_issue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .entry_value_i (entry_value_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .row_count_i   (row_count_i),
    .hold_i        (hold),
    .wr_i          (wr),
    .re_o          (re),
    .raddr_o       (raddr),
    .s1_o          (s1)
  );

  tmps_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_ROWS)
  ) u_best_row (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tmps_update u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_i        (s1),
    .rdata_i     (rdata),
    .wr_o        (wr),
    .hold_o      (hold),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .max_sum_o   (max_sum_o)
  );

endmodule

>>> rtl/tmps_ram.sv
// ----------------------------------------------------------------------------
// tmps_ram: generic single-write, single-read RAM
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module tmps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tmps_issue.sv
// ----------------------------------------------------------------------------
// tmps_issue: input acceptance, position tracking and row-store read issue
// holds the last-row index, steps column and row, flags same-entry forwarding
// ----------------------------------------------------------------------------
module tmps_issue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tmps_pkg::VAL_W-1:0]    entry_value_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tmps_pkg::CNT_W-1:0]    row_count_i,
  input  logic                          hold_i,
  input  tmps_pkg::wr_t                 wr_i,
  output logic                          re_o,
  output logic [tmps_pkg::ROW_W-1:0]    raddr_o,
  output tmps_pkg::issue_t              s1_o
);
  import tmps_pkg::*;

  logic [ROW_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [ROW_W-1:0] last_q;
  issue_t           s1_q, s1_d;
  logic             accept;
  logic             diag;
  logic             last_row_hit;

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = hold_i;
  assign accept       = in_valid_i & ~hold_i;
  assign diag         = (col_q == row_q);
  assign last_row_hit = (row_q >= last_q);

  // the previous row only has entries left of the diagonal
  assign re_o    = accept & (col_q < row_q);
  assign raddr_o = col_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    s1_d  = s1_q;
    if (accept) begin
      if (diag) begin
        col_d = '0;
        row_d = last_row_hit ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
      s1_d.valid     = 1'b1;
      s1_d.value     = entry_value_i;
      s1_d.addr      = col_q;
      s1_d.first_col = (col_q == '0);
      s1_d.diag      = diag;
      s1_d.top_row   = (row_q == '0);
      s1_d.rd_en     = re_o;
      s1_d.last      = diag & last_row_hit;
      // entry written by the update stage this cycle is not yet in the ram
      s1_d.fwd       = wr_i.en & (wr_i.addr == col_q);
      s1_d.fwd_data  = wr_i.data;
    end else if (!hold_i) begin
      s1_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      last_q <= last_row(CNT_W'(4));
      s1_q   <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      s1_q  <= s1_d;
      if (cfg_valid_i && cfg_ready_o) begin
        last_q <= last_row(row_count_i);
      end
    end
  end

  assign s1_o = s1_q;

endmodule

>>> rtl/tmps_update.sv
// ----------------------------------------------------------------------------
// tmps_update: parent selection, saturating add and row-store write back
// keeps the left-parent carry, the running row maximum and the result register
// ----------------------------------------------------------------------------
module tmps_update (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tmps_pkg::issue_t           s1_i,
  input  logic [tmps_pkg::SUM_W-1:0] rdata_i,
  output tmps_pkg::wr_t              wr_o,
  output logic                       hold_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tmps_pkg::SUM_W-1:0] max_sum_o
);
  import tmps_pkg::*;

  logic [SUM_W-1:0] left_q;
  logic [SUM_W-1:0] row_best_q, row_best_d;
  logic             out_valid_q;
  logic [SUM_W-1:0] max_sum_q;
  logic [SUM_W-1:0] old_here;
  logic [SUM_W-1:0] parent;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum;
  logic             fire;

  // a finishing item waits only while the result register is still taken
  assign hold_o = s1_i.valid & s1_i.last & out_valid_q & out_stall_i;
  assign fire   = s1_i.valid & ~hold_o;

  always_comb begin
    if (!s1_i.rd_en) begin
      old_here = '0;
    end else if (s1_i.fwd) begin
      old_here = s1_i.fwd_data;
    end else begin
      old_here = rdata_i;
    end

    if (s1_i.top_row) begin
      parent = '0;
    end else if (s1_i.first_col) begin
      parent = old_here;
    end else if (s1_i.diag) begin
      parent = left_q;
    end else begin
      parent = (old_here > left_q) ? old_here : left_q;
    end

    sum_wide = {{(SUM_W + 1 - VAL_W){1'b0}}, s1_i.value} + {1'b0, parent};
    sum      = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];

    row_best_d = (s1_i.first_col || sum > row_best_q) ? sum : row_best_q;
  end

  assign wr_o.en   = fire;
  assign wr_o.addr = s1_i.addr;
  assign wr_o.data = sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      row_best_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        left_q     <= old_here;
        row_best_q <= row_best_d;
      end
      if (fire && s1_i.last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && s1_i.last) begin
      max_sum_q <= row_best_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign max_sum_o   = max_sum_q;

endmodule

>>> rtl/tmps_checker.sv
// ----------------------------------------------------------------------------
// tmps_checker: port-level checks for the triangle path-sum block
// result hold under stall, no drop before taken, input stall cause, result range
// ----------------------------------------------------------------------------
module tmps_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [tmps_pkg::SUM_W-1:0] max_sum_o
);
  import tmps_pkg::*;

  localparam int unsigned PathMax = ((1 << VAL_W) - 1) * MAX_ROWS;
  localparam logic [SUM_W-1:0] SumBound =
    (PathMax > int'(SUM_MAX)) ? SUM_MAX : SUM_W'(PathMax);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(max_sum_o))
    else $error("result changed or dropped while stalled");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result withdrawn without being taken");

  // input back-pressure comes only from a taken, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> max_sum_o <= SumBound)
    else $error("path sum beyond reachable range");

endmodule

bind triangle_max_path_sum_top tmps_checker u_tmps_checker (.*);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: triangle maximum path sum, self-checking
// streams triangle entries under random sender gaps and receiver stalls and
// checks each emitted path sum against a cycle-free predictor of the block;
// covers row-count clamping, row-count changes mid-triangle, 64-row extremes
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tmps_pkg::*;

  localparam int unsigned DIR_N      = 25;
  localparam int unsigned RAND_ITEMS = 400;
  localparam int unsigned FULL_ITEMS = MAX_ROWS * (MAX_ROWS + 1) / 2;
  localparam int unsigned WDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_WAIT = 8;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic [VAL_W-1:0] entry_value_i = '0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic [SUM_W-1:0] max_sum_o;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] row_count_i   = '0;

  triangle_max_path_sum_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .entry_value_i (entry_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .max_sum_o     (max_sum_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .row_count_i   (row_count_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: best sums of the previous row, positions and carries
  logic [SUM_W-1:0] path_row [MAX_ROWS];
  int unsigned      col_q;
  int unsigned      row_q;
  int unsigned      left_q;
  int unsigned      peak_q;
  logic [CNT_W-1:0] rows_cfg;

  logic [SUM_W-1:0] max_sum_q [$];
  int unsigned      err_cnt;
  bit               quiet;

  typedef struct {
    bit               do_cfg;
    logic [CNT_W-1:0] cfg_val;
    logic [VAL_W-1:0] entry;
    bit               typed;
    logic [SUM_W-1:0] sum;
  } step_t;

  step_t dir_steps [DIR_N] = '{
    // reset row count of four, all entries at the top value
    '{1'b0, 7'd0,   8'd255, 1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd255, 1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd255, 1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd255, 1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd255, 1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd255, 1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd255, 1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd255, 1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd255, 1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd255, 1'b1, 14'd1020},
    // zero rows acts as one row
    '{1'b1, 7'd0,   8'd0,   1'b1, 14'd0},
    '{1'b0, 7'd0,   8'd255, 1'b1, 14'd255},
    '{1'b1, 7'd1,   8'd7,   1'b1, 14'd7},
    // three rows with competing parents
    '{1'b1, 7'd3,   8'd1,   1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd9,   1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd2,   1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd3,   1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd8,   1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd4,   1'b0, 14'd0},
    // row count cut below the current row mid-triangle
    '{1'b1, 7'd5,   8'd10,  1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd20,  1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd30,  1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd40,  1'b0, 14'd0},
    '{1'b1, 7'd2,   8'd50,  1'b0, 14'd0},
    '{1'b0, 7'd0,   8'd60,  1'b0, 14'd0}
  };

  function automatic bit predict_entry(input logic [VAL_W-1:0] v,
                                       output logic [SUM_W-1:0] total);
    int unsigned x, y, last_y, here, parent, s;
    x = col_q;
    y = row_q;
    if (rows_cfg == 0) last_y = 0;
    else if (rows_cfg > MAX_ROWS) last_y = MAX_ROWS - 1;
    else last_y = rows_cfg - 1;
    here = 0;
    if (x < y) here = path_row[x];
    if (y == 0) parent = 0;
    else if (x == 0) parent = here;
    else if (x == y) parent = left_q;
    else parent = (here > left_q) ? here : left_q;
    s = v + parent;
    if (s > SUM_MAX) s = SUM_MAX;
    path_row[x] = SUM_W'(s);
    left_q = here;
    if (x == 0 || s > peak_q) peak_q = s;
    total = SUM_W'(peak_q);
    if (x == y) begin
      col_q = 0;
      if (y >= last_y) begin
        row_q = 0;
        return 1'b1;
      end
      row_q = y + 1;
    end else begin
      col_q = x + 1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [VAL_W-1:0] pick_entry();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VAL_W'($urandom_range(0, 255));
  endfunction

  task automatic send_entry(input logic [VAL_W-1:0] v, input bit typed,
                            input logic [SUM_W-1:0] typed_sum);
    int unsigned      gap;
    logic [SUM_W-1:0] sum;
    bit               got;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    entry_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    got = predict_entry(v, sum);
    if (typed && !got) report_mismatch("item should have completed a triangle");
    if (got) max_sum_q.push_back(typed ? typed_sum : sum);
  endtask

  // write the row count once every pending sum is out and the pipe is empty
  task automatic write_rows(input logic [CNT_W-1:0] cnt);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (max_sum_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    row_count_i <= cnt;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    rows_cfg = cnt;
  endtask

  // receiver stalls: short bursts mostly, a few long ones
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (quiet || $urandom_range(0, 99) < 60) begin
      out_stall_i <= 1'b0;
    end else begin
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                  : $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    logic [SUM_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (max_sum_q.size() == 0) begin
        report_mismatch($sformatf("unexpected max_sum %0d", max_sum_o));
      end else begin
        want = max_sum_q.pop_front();
        if (max_sum_o !== want)
          report_mismatch($sformatf("max_sum %0d, want %0d", max_sum_o, want));
      end
    end
  end

  // watchdog on cycles without any item moving
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned rand_sent;
    int unsigned n;
    int unsigned r;
    logic [CNT_W-1:0] cnt;
    err_cnt  = 0;
    quiet    = 1'b0;
    col_q    = 0;
    row_q    = 0;
    left_q   = 0;
    peak_q   = 0;
    rows_cfg = CNT_W'(4);
    foreach (path_row[i]) path_row[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_steps[i]) begin
      if (dir_steps[i].do_cfg) write_rows(dir_steps[i].cfg_val);
      send_entry(dir_steps[i].entry, dir_steps[i].typed, dir_steps[i].sum);
    end

    // deepest triangle at the top value, row count clamped from the largest code
    write_rows('1);
    for (int unsigned i = 0; i < FULL_ITEMS; i++)
      send_entry('1, i == FULL_ITEMS - 1, SUM_W'(MAX_ROWS * 255));

    // random phases; phase ends leave triangles cut at random points
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r == 0) cnt = '0;
      else if (r == 1) cnt = CNT_W'($urandom_range(MAX_ROWS + 1, 127));
      else if (r == 2) cnt = CNT_W'(MAX_ROWS);
      else cnt = CNT_W'($urandom_range(1, 8));
      write_rows(cnt);
      quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, 40);
      repeat (n) send_entry(pick_entry(), 1'b0, '0);
      rand_sent += n;
      quiet = 1'b0;
    end

    in_valid_i <= 1'b0;
    while (max_sum_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
